>>> rtl/pft_pkg.sv
// shared types, constants and the microcode table of the fan triangulator
// no dependencies
`default_nettype none

package pft_pkg;

    localparam int MAX_FACE_VERTS   = 32;
    localparam int POINT_INDEX_BITS = 24;
    localparam int BUF_AW           = $clog2(MAX_FACE_VERTS);
    localparam int VCNT_W           = $clog2(MAX_FACE_VERTS + 1);
    localparam int NPTS_W           = 25;
    localparam int TOTAL_W          = 32;
    localparam int CURSOR_W         = 33;
    localparam int COUNT_W          = 31;
    localparam int MIN_FACE         = 3;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_HEADER = 2'd1;
    localparam logic [1:0] OP_VERTEX = 2'd2;

    localparam logic PK_TRI  = 1'b0;
    localparam logic PK_LINE = 1'b1;

    localparam logic REG_NUM_POINTS    = 1'b0;
    localparam logic REG_TOTAL_INDICES = 1'b1;

    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] UA_IDLE  = 3'd0;
    localparam logic [UPC_W-1:0] UA_FETCH = 3'd1;
    localparam logic [UPC_W-1:0] UA_EDGE0 = 3'd2;
    localparam logic [UPC_W-1:0] UA_TRI   = 3'd3;
    localparam logic [UPC_W-1:0] UA_EDGE  = 3'd4;
    localparam logic [UPC_W-1:0] UA_CLOSE = 3'd5;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic                        prim_kind;
        logic [POINT_INDEX_BITS-1:0] vert_a;
        logic [POINT_INDEX_BITS-1:0] vert_b;
        logic [POINT_INDEX_BITS-1:0] vert_c;
        logic                        last;
    } t_out_item;

    typedef enum logic [1:0] {
        VS_ZERO = 2'd0,
        VS_V0   = 2'd1,
        VS_RD   = 2'd2,
        VS_PREV = 2'd3
    } t_vsel;

    typedef enum logic [1:0] {
        JC_NONE      = 2'd0,
        JC_FACE_DONE = 2'd1,
        JC_J_END     = 2'd2
    } t_jcond;

    typedef struct packed {
        logic             accept;
        logic             emit;
        logic             kind;
        t_vsel            sel_a;
        t_vsel            sel_b;
        t_vsel            sel_c;
        logic             last;
        logic             rd;
        logic             prev_ld;
        t_jcond           jc;
        logic [UPC_W-1:0] tgt;
        logic [UPC_W-1:0] nxt;
    } t_uword;

    typedef struct packed {
        logic step_go;
        logic face_done;
        logic j_end;
    } t_seq_stat;

    function automatic t_uword ucode_rom(input logic [UPC_W-1:0] upc);
        t_uword w;
        w = '{accept: 1'b0, emit: 1'b0, kind: PK_LINE, sel_a: VS_ZERO, sel_b: VS_ZERO,
              sel_c: VS_ZERO, last: 1'b0, rd: 1'b0, prev_ld: 1'b0, jc: JC_NONE,
              tgt: UA_IDLE, nxt: UA_IDLE};
        case (upc)
            UA_IDLE: begin
                w.accept = 1'b1;
                w.jc     = JC_FACE_DONE;
                w.tgt    = UA_FETCH;
                w.nxt    = UA_IDLE;
            end
            UA_FETCH: begin
                w.rd  = 1'b1;
                w.nxt = UA_EDGE0;
            end
            UA_EDGE0: begin
                w.emit    = 1'b1;
                w.kind    = PK_LINE;
                w.sel_a   = VS_V0;
                w.sel_b   = VS_RD;
                w.rd      = 1'b1;
                w.prev_ld = 1'b1;
                w.nxt     = UA_TRI;
            end
            UA_TRI: begin
                w.emit  = 1'b1;
                w.kind  = PK_TRI;
                w.sel_a = VS_V0;
                w.sel_b = VS_RD;
                w.sel_c = VS_PREV;
                w.nxt   = UA_EDGE;
            end
            UA_EDGE: begin
                w.emit    = 1'b1;
                w.kind    = PK_LINE;
                w.sel_a   = VS_PREV;
                w.sel_b   = VS_RD;
                w.rd      = 1'b1;
                w.prev_ld = 1'b1;
                w.jc      = JC_J_END;
                w.tgt     = UA_CLOSE;
                w.nxt     = UA_TRI;
            end
            UA_CLOSE: begin
                w.emit  = 1'b1;
                w.kind  = PK_LINE;
                w.sel_a = VS_PREV;
                w.sel_b = VS_V0;
                w.last  = 1'b1;
                w.nxt   = UA_IDLE;
            end
            default: begin
                w.nxt = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pft_seq.sv
// microprogram sequencer: step counter, control table lookup, conditional jumps
// depends on pft_pkg
`default_nettype none

module pft_seq (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire pft_pkg::t_seq_stat  i_stat,
    output pft_pkg::t_uword          o_uword
);
    import pft_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           uw;
    logic             take_jump;

    assign uw      = ucode_rom(r_upc);
    assign o_uword = uw;

    always_comb begin
        case (uw.jc)
            JC_FACE_DONE: take_jump = i_stat.face_done;
            JC_J_END:     take_jump = i_stat.j_end;
            default:      take_jump = 1'b0;
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        if (i_stat.step_go) begin
            n_upc = take_jump ? uw.tgt : uw.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

>>> rtl/polygon_fan_triangulator.sv
// top level of the polygon fan triangulator: input decode, face buffer, output register
// depends on pft_pkg and pft_seq
//
//   channel | direction | handshake              | payload
//   in      | into      | i_in_valid / o_in_ready | i_in_data  (t_in_item)
//   out     | out of    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//   config  | into      | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// every item is taken in the idle step; the item that completes a valid face of n
// vertices then holds input off for one buffer fetch and 2n-2 primitives, one per cycle
// while the output does not stall, as the sequencer walks the single face buffer read
// port. a stalled output freezes the sequencer on its emitting step; the output register
// lets the next item in while the closing edge still waits. reset is synchronous, active
// low, clears control registers, counters and flags; face buffer and data need no clearing
`default_nettype none

module polygon_fan_triangulator (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire pft_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output pft_pkg::t_out_item       o_out_data,
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire  [2:0]               paddr,
    input  wire  [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import pft_pkg::*;

    logic [NPTS_W-1:0]           r_num_points;
    logic [TOTAL_W-1:0]          r_total;
    logic [CURSOR_W-1:0]         r_cursor;
    logic [COUNT_W-1:0]          r_face_len;
    logic [COUNT_W-1:0]          r_vpos;
    logic                        r_inv;
    logic                        r_stopped;
    logic [VCNT_W-1:0]           r_j;
    logic [POINT_INDEX_BITS-1:0] r_mem [MAX_FACE_VERTS];
    logic [POINT_INDEX_BITS-1:0] r_rd;
    logic [POINT_INDEX_BITS-1:0] r_v0;
    logic [POINT_INDEX_BITS-1:0] r_prev;
    logic                        r_out_valid;
    t_out_item                   r_out;

    t_uword      uw;
    t_seq_stat   stat;
    logic        in_fire;
    logic [1:0]  op;
    logic [31:0] raw;
    logic        neg;
    logic [CURSOR_W:0] hdr_sum;
    logic [CURSOR_W-1:0] hdr_sat;
    logic        hdr_short;
    logic        hdr_over;
    logic        vp_open;
    logic        bad_idx;
    logic [COUNT_W-1:0] vp_next;
    logic        vert_take;
    logic        face_done;
    logic        buf_wr;
    logic        out_free;
    logic        step_go;
    logic        out_load;
    logic        cfg_wr;
    t_out_item   prim;

    pft_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uw)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_NUM_POINTS:    prdata = {{(32-NPTS_W){1'b0}}, r_num_points};
            REG_TOTAL_INDICES: prdata = r_total;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= '0;
            r_total      <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_NUM_POINTS) begin
                r_num_points <= pwdata[NPTS_W-1:0];
            end else begin
                r_total <= pwdata[TOTAL_W-1:0];
            end
        end
    end

    // input decode
    assign o_in_ready = uw.accept;
    assign in_fire    = i_in_valid && uw.accept;
    assign op         = i_in_data.operation;
    assign raw        = i_in_data.value;
    assign neg        = raw[31];

    assign hdr_sum   = {1'b0, r_cursor} + {{(CURSOR_W+1-32){1'b0}}, raw};
    assign hdr_sat   = hdr_sum[CURSOR_W] ? {CURSOR_W{1'b1}} : hdr_sum[CURSOR_W-1:0];
    assign hdr_short = raw < 32'(MIN_FACE);
    assign hdr_over  = !hdr_short && (hdr_sum > {{(CURSOR_W+1-TOTAL_W){1'b0}}, r_total});

    assign vp_open   = r_vpos < r_face_len;
    assign bad_idx   = neg || (raw >= {{(32-NPTS_W){1'b0}}, r_num_points});
    assign vp_next   = r_vpos + 1'b1;
    assign vert_take = in_fire && (op == OP_VERTEX) && !r_stopped && vp_open;
    assign buf_wr    = vert_take && (r_vpos < COUNT_W'(MAX_FACE_VERTS));
    assign face_done = vert_take && (vp_next == r_face_len) && !(r_inv || bad_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor   <= '0;
            r_face_len <= '0;
            r_vpos     <= '0;
            r_inv      <= 1'b0;
            r_stopped  <= 1'b0;
        end else if (in_fire) begin
            if (op == OP_START) begin
                r_cursor   <= '0;
                r_face_len <= '0;
                r_vpos     <= '0;
                r_inv      <= 1'b0;
                r_stopped  <= 1'b0;
            end else if (op == OP_HEADER && !r_stopped) begin
                r_face_len <= '0;
                r_vpos     <= '0;
                r_inv      <= 1'b0;
                if (neg || hdr_over) begin
                    r_stopped <= 1'b1;
                end else begin
                    r_cursor   <= hdr_sat;
                    r_face_len <= raw[COUNT_W-1:0];
                    r_inv      <= hdr_short || (raw > 32'(MAX_FACE_VERTS));
                end
            end else if (vert_take) begin
                r_vpos <= vp_next;
                if (bad_idx) begin
                    r_inv <= 1'b1;
                end
            end
        end
    end

    // face buffer, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (buf_wr) begin
            r_mem[r_vpos[BUF_AW-1:0]] <= raw[POINT_INDEX_BITS-1:0];
        end
        if (step_go && uw.rd) begin
            r_rd <= r_mem[r_j[BUF_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_wr && r_vpos == '0) begin
            r_v0 <= raw[POINT_INDEX_BITS-1:0];
        end
        if (step_go && uw.prev_ld) begin
            r_prev <= r_rd;
        end
    end

    // fetch index: starts at the second vertex when a face completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
        end else if (face_done) begin
            r_j <= VCNT_W'(1);
        end else if (step_go && uw.rd) begin
            r_j <= r_j + 1'b1;
        end
    end

    // sequencer status
    assign out_free       = !r_out_valid || i_out_ready;
    assign step_go        = !uw.emit || out_free;
    assign out_load       = uw.emit && out_free;
    assign stat.step_go   = step_go;
    assign stat.face_done = face_done;
    assign stat.j_end     = {{(COUNT_W-VCNT_W){1'b0}}, r_j} == r_face_len;

    function automatic logic [POINT_INDEX_BITS-1:0] vpick(
        input t_vsel                       s,
        input logic [POINT_INDEX_BITS-1:0] v0,
        input logic [POINT_INDEX_BITS-1:0] rd,
        input logic [POINT_INDEX_BITS-1:0] prev
    );
        logic [POINT_INDEX_BITS-1:0] v;
        case (s)
            VS_V0:   v = v0;
            VS_RD:   v = rd;
            VS_PREV: v = prev;
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        prim.prim_kind = uw.kind;
        prim.vert_a    = vpick(uw.sel_a, r_v0, r_rd, r_prev);
        prim.vert_b    = vpick(uw.sel_b, r_v0, r_rd, r_prev);
        prim.vert_c    = vpick(uw.sel_c, r_v0, r_rd, r_prev);
        prim.last      = uw.last;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= prim;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_reset_out_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_face_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        face_done |-> (r_face_len >= COUNT_W'(MIN_FACE)
                       && r_face_len <= COUNT_W'(MAX_FACE_VERTS)))
        else $error("face emitted with out-of-range vertex count");

    a_close_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && uw.last) |=> o_in_ready)
        else $error("sequencer did not return to idle after closing edge");

    a_fetch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> ({{(32-VCNT_W){1'b0}}, r_j} <= {1'b0, r_face_len} + 32'd1))
        else $error("fetch index ran past the face");

endmodule

`default_nettype wire
